>>> sv/gic_pkg.sv
`default_nettype none

package gic_pkg;

    // sizes
    localparam int SLOT_COUNT   = 16;
    localparam int BUTTON_COUNT = 32;
    localparam int HAT_SLOTS    = 4;
    localparam int HAT_SECTOR   = 4500;
    localparam int HAT_SECTORS  = 8;

    // iteration counts of the shared root and divide steps
    localparam int SQRT_STEPS = 16;
    localparam int DIV_STEPS  = 15;

    // configuration register indexes
    localparam logic [1:0] CFG_AXIS_SELECT   = 2'd0;
    localparam logic [1:0] CFG_BUTTON_SELECT = 2'd1;
    localparam logic [1:0] CFG_STICK_LIMIT   = 2'd2;

    // configuration reset values
    localparam logic [11:0] AXIS_SELECT_RST   = 12'd2696;
    localparam logic [59:0] BUTTON_SELECT_RST = 60'd370850165750367330;
    localparam logic [14:0] STICK_LIMIT_RST   = 15'd1000;

    // slot state codes
    localparam logic [1:0] SLOT_IDLE     = 2'd0;
    localparam logic [1:0] SLOT_HELD     = 2'd1;
    localparam logic [1:0] SLOT_RELEASED = 2'd2;
    localparam logic [1:0] SLOT_PRESSED  = 2'd3;

    typedef logic [1:0] slot_state_t;

    // direction bits for each hat sector, last entry is centred
    localparam logic [3:0] HAT_DIR_TABLE [HAT_SECTORS + 1] = '{
        4'h1, 4'h9, 4'h8, 4'hA, 4'h2, 4'h6, 4'h4, 4'h5, 4'h0
    };

    // edge tracking of one level
    function automatic slot_state_t slot_next(input slot_state_t old, input logic level);
        slot_state_t res;
        if (old[0])
            res = level ? SLOT_HELD : SLOT_RELEASED;
        else
            res = level ? SLOT_PRESSED : SLOT_IDLE;
        return res;
    endfunction

    // hat angle to direction bits, sector found by threshold compares
    function automatic logic [3:0] hat_dirs(input logic [15:0] hat);
        int idx;
        idx = HAT_SECTORS;
        if (32'(hat) < HAT_SECTORS * HAT_SECTOR)
        begin
            idx = 0;
            for (int k = 1; k < HAT_SECTORS; k++)
            begin
                if (32'(hat) >= k * HAT_SECTOR)
                    idx = k;
            end
        end
        return HAT_DIR_TABLE[idx];
    endfunction

    // magnitude of a signed 16-bit value
    function automatic logic [15:0] mag16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

`default_nettype wire

>>> sv/gamepad_input_conditioner.sv
// each input word runs the square, sum and compare steps for each stick; a stick that needs
// clamping also runs a 16-step square root and two 15-step divisions on the shared units
// a new word is taken once the previous result sits in the output register, so the sequencer
// takes no new word while one is still in work on the shared subtractor and multiplier
// reset: rst_n asynchronous active low clears slot states and sequencer, loads default config
`default_nettype none

module gamepad_input_conditioner
    import gic_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // config write channel
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [59:0]  cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // raw_x, raw_y, raw_z, raw_rot_x, raw_rot_y, raw_rot_z, hat_angle,
    // pad_buttons, slot_keys, dir_keys
    input  wire logic [167:0] s_tdata,
    // pad_present
    input  wire logic         s_tuser,
    // output stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // left_x, left_y, right_x, right_y, slot_states
    output logic [95:0]       m_tdata
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_MX   = 11'b000_0000_0010,
        S_MY   = 11'b000_0000_0100,
        S_ML   = 11'b000_0000_1000,
        S_CMP  = 11'b000_0001_0000,
        S_SQRT = 11'b000_0010_0000,
        S_MULX = 11'b000_0100_0000,
        S_DIVX = 11'b000_1000_0000,
        S_MULY = 11'b001_0000_0000,
        S_DIVY = 11'b010_0000_0000,
        S_FIN  = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   stick_reg, stick_next;
    logic   out_valid_reg, out_valid_next;

    logic [11:0] axis_sel_reg;
    logic [59:0] button_sel_reg;
    logic [14:0] stick_limit_reg;

    slot_state_t pad_state_reg [SLOT_COUNT];
    slot_state_t merged_reg    [SLOT_COUNT];
    slot_state_t pad_state_next [SLOT_COUNT];
    slot_state_t merged_next    [SLOT_COUNT];

    // working stick and pending stick
    logic signed [15:0] wx_reg, wy_reg, px_reg, py_reg;
    logic [31:0] sum_reg, prod_reg;
    logic [31:0] src_reg;
    logic [16:0] rem_reg;
    logic [15:0] acc_reg;
    logic [15:0] r_reg;
    logic [3:0]  cnt_reg;

    logic [15:0] out_lx_reg, out_ly_reg, out_rx_reg, out_ry_reg;
    logic [31:0] out_slots_reg;

    logic in_acc, out_take, fin_go, clamp, sqrt_last, div_last;

    // unpacked input fields
    logic        present;
    logic [95:0] raw_axes;
    logic [15:0] hat;
    logic [31:0] pad_buttons;
    logic [15:0] slot_keys;
    logic [7:0]  dir_keys;
    logic [3:0]  hat_bits;
    logic signed [15:0] lim_s;
    logic signed [15:0] st [4];
    logic signed [15:0] lx_in, ly_in, rx_in, ry_in;

    // shared multiplier and subtractor
    logic [15:0] mul_a, mul_b;
    logic [31:0] mul_p;
    logic [18:0] sub_a, sub_b;
    logic [19:0] sub_d;
    logic        sub_ge;
    logic [15:0] quo;
    logic signed [15:0] quo_x, quo_y;
    logic [31:0] slots_packed;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_slots_reg, out_ry_reg, out_rx_reg, out_ly_reg, out_lx_reg};

    assign in_acc   = s_tvalid && s_tready;
    assign out_take = out_valid_reg && m_tready;
    assign fin_go   = (state_reg == S_FIN) && (!out_valid_reg || m_tready);
    assign clamp    = sum_reg > prod_reg;
    assign sqrt_last = (cnt_reg == 4'(SQRT_STEPS - 1));
    assign div_last  = (cnt_reg == 4'(DIV_STEPS - 1));

    assign present     = s_tuser;
    assign raw_axes    = s_tdata[95:0];
    assign hat         = s_tdata[111:96];
    assign pad_buttons = s_tdata[143:112];
    assign slot_keys   = s_tdata[159:144];
    assign dir_keys    = s_tdata[167:160];
    assign hat_bits    = hat_dirs(hat);
    assign lim_s       = signed'({1'b0, stick_limit_reg});

    function automatic logic signed [15:0] pick_axis(input logic [95:0] raw,
                                                     input logic [2:0] sel);
        logic signed [15:0] v;
        case (sel)
            3'd0:    v = raw[15:0];
            3'd1:    v = raw[31:16];
            3'd2:    v = raw[47:32];
            3'd3:    v = raw[63:48];
            3'd4:    v = raw[79:64];
            3'd5:    v = raw[95:80];
            default: v = '0;
        endcase
        return v;
    endfunction

    // axis selection and direction key override
    always_comb
    begin
        for (int i = 0; i < 4; i++)
            st[i] = present ? pick_axis(raw_axes, axis_sel_reg[3*i +: 3]) : 16'sd0;
        lx_in = dir_keys[3] ? lim_s : (dir_keys[2] ? -lim_s : st[0]);
        ly_in = dir_keys[1] ? lim_s : (dir_keys[0] ? -lim_s : st[1]);
        rx_in = dir_keys[7] ? lim_s : (dir_keys[6] ? -lim_s : st[2]);
        ry_in = dir_keys[5] ? lim_s : (dir_keys[4] ? -lim_s : st[3]);
    end

    // slot state update for the incoming word
    always_comb
    begin
        logic       lvl;
        logic [4:0] bsel;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (i < HAT_SLOTS)
            begin
                bsel = '0;
                lvl  = hat_bits[i];
            end
            else
            begin
                bsel = button_sel_reg[5*(i-HAT_SLOTS) +: 5];
                lvl  = (int'(bsel) < BUTTON_COUNT) && pad_buttons[bsel];
            end
            pad_state_next[i] = present ? slot_next(pad_state_reg[i], lvl) : pad_state_reg[i];
            if (present && (pad_state_next[i] != SLOT_IDLE))
                merged_next[i] = pad_state_next[i];
            else
                merged_next[i] = slot_next(merged_reg[i], slot_keys[i]);
        end
    end

    // pack merged slot states
    always_comb
    begin
        slots_packed = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
            slots_packed[2*i +: 2] = merged_reg[i];
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_MX:    begin mul_a = mag16(wx_reg); mul_b = mag16(wx_reg); end
            S_MY:    begin mul_a = mag16(wy_reg); mul_b = mag16(wy_reg); end
            S_ML:    begin mul_a = 16'(stick_limit_reg); mul_b = 16'(stick_limit_reg); end
            S_MULX:  begin mul_a = mag16(wx_reg); mul_b = 16'(stick_limit_reg); end
            S_MULY:  begin mul_a = mag16(wy_reg); mul_b = 16'(stick_limit_reg); end
            default: ;
        endcase
        mul_p = mul_a * mul_b;
    end

    // subtractor operand select: root digit trial or quotient bit trial
    always_comb
    begin
        sub_a = '0;
        sub_b = '0;
        unique case (state_reg)
            S_SQRT:
            begin
                sub_a = {rem_reg, src_reg[31:30]};
                sub_b = {1'b0, acc_reg, 2'b01};
            end
            S_DIVX, S_DIVY:
            begin
                sub_a = {2'b00, rem_reg[15:0], src_reg[31]};
                sub_b = {3'b000, r_reg};
            end
            default: ;
        endcase
        sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge = !sub_d[19];
        quo    = {1'b0, acc_reg[13:0], sub_ge};
        quo_x  = wx_reg[15] ? -signed'(quo) : signed'(quo);
        quo_y  = wy_reg[15] ? -signed'(quo) : signed'(quo);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        stick_next     = stick_reg;
        out_valid_next = out_valid_reg;
        if (out_take)
            out_valid_next = 1'b0;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_ML;
            S_ML:   state_next = S_CMP;
            S_CMP:
            begin
                if (clamp)
                    state_next = S_SQRT;
                else if (stick_reg)
                    state_next = S_FIN;
                else
                begin
                    state_next = S_MX;
                    stick_next = 1'b1;
                end
            end
            S_SQRT: if (sqrt_last) state_next = S_MULX;
            S_MULX: state_next = S_DIVX;
            S_DIVX: if (div_last) state_next = S_MULY;
            S_MULY: state_next = S_DIVY;
            S_DIVY:
            begin
                if (div_last)
                begin
                    if (stick_reg)
                        state_next = S_FIN;
                    else
                    begin
                        state_next = S_MX;
                        stick_next = 1'b1;
                    end
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next     = S_IDLE;
                    stick_next     = 1'b0;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state, configuration and slot states
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            stick_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            axis_sel_reg    <= AXIS_SELECT_RST;
            button_sel_reg  <= BUTTON_SELECT_RST;
            stick_limit_reg <= STICK_LIMIT_RST;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                pad_state_reg[i] <= SLOT_IDLE;
                merged_reg[i]    <= SLOT_IDLE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            stick_reg     <= stick_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_AXIS_SELECT:   axis_sel_reg    <= cfg_data[11:0];
                    CFG_BUTTON_SELECT: button_sel_reg  <= cfg_data;
                    CFG_STICK_LIMIT:   stick_limit_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (in_acc)
            begin
                for (int i = 0; i < SLOT_COUNT; i++)
                begin
                    pad_state_reg[i] <= pad_state_next[i];
                    merged_reg[i]    <= merged_next[i];
                end
            end
        end
    end

    // stick datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    wx_reg <= lx_in;
                    wy_reg <= ly_in;
                    px_reg <= rx_in;
                    py_reg <= ry_in;
                end
            end
            S_MX: prod_reg <= mul_p;
            S_MY:
            begin
                prod_reg <= mul_p;
                sum_reg  <= prod_reg;
            end
            S_ML:
            begin
                prod_reg <= mul_p;
                sum_reg  <= sum_reg + prod_reg;
            end
            S_CMP:
            begin
                src_reg <= sum_reg;
                rem_reg <= '0;
                acc_reg <= '0;
                cnt_reg <= '0;
                if (!clamp && !stick_reg)
                begin
                    wx_reg <= px_reg;
                    wy_reg <= py_reg;
                    px_reg <= wx_reg;
                    py_reg <= wy_reg;
                end
            end
            S_SQRT:
            begin
                rem_reg <= sub_ge ? sub_d[16:0] : sub_a[16:0];
                acc_reg <= {acc_reg[14:0], sub_ge};
                src_reg <= {src_reg[29:0], 2'b00};
                cnt_reg <= cnt_reg + 4'd1;
                if (sqrt_last)
                    r_reg <= {acc_reg[14:0], sub_ge};
            end
            S_MULX, S_MULY:
            begin
                rem_reg <= {2'b00, mul_p[29:15]};
                src_reg <= {mul_p[14:0], 17'd0};
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIVX:
            begin
                rem_reg <= {1'b0, sub_ge ? sub_d[15:0] : sub_a[15:0]};
                acc_reg <= {acc_reg[14:0], sub_ge};
                src_reg <= {src_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (div_last)
                    wx_reg <= quo_x;
            end
            S_DIVY:
            begin
                rem_reg <= {1'b0, sub_ge ? sub_d[15:0] : sub_a[15:0]};
                acc_reg <= {acc_reg[14:0], sub_ge};
                src_reg <= {src_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 4'd1;
                if (div_last)
                begin
                    if (stick_reg)
                        wy_reg <= quo_y;
                    else
                    begin
                        wx_reg <= px_reg;
                        wy_reg <= py_reg;
                        px_reg <= wx_reg;
                        py_reg <= quo_y;
                    end
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    out_lx_reg    <= px_reg;
                    out_ly_reg    <= py_reg;
                    out_rx_reg    <= wx_reg;
                    out_ry_reg    <= wy_reg;
                    out_slots_reg <= slots_packed;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/gic_checker.sv
`default_nettype none

module gic_checker
    import gic_pkg::*;
(
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic [1:0]   cfg_index,
    input wire logic [59:0]  cfg_data,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [95:0]  m_tdata
);

    logic [14:0] lim_reg;
    logic [15:0] mag_lx, mag_ly, mag_rx, mag_ry;
    logic        in_word_seen;

    // track the stick limit from the config channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_reg <= STICK_LIMIT_RST;
        else if (cfg_valid && cfg_ready && (cfg_index == CFG_STICK_LIMIT))
            lim_reg <= cfg_data[14:0];
    end

    always_comb
    begin
        mag_lx = mag16(m_tdata[15:0]);
        mag_ly = mag16(m_tdata[31:16]);
        mag_rx = mag16(m_tdata[47:32]);
        mag_ry = mag16(m_tdata[63:48]);
        in_word_seen = s_tvalid && s_tready;
    end

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // sequencer is busy right after taking a word
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_word_seen |=> !s_tready)
        else $error("input taken again in the cycle after a word");

    // no new output appears right after a word is taken while none was pending
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_word_seen && !m_tvalid |=> !m_tvalid)
        else $error("result appeared one cycle after input");

    // no stick component exceeds the configured stick limit
    a_radius: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mag_lx <= 16'(lim_reg)) && (mag_ly <= 16'(lim_reg)) &&
                     (mag_rx <= 16'(lim_reg)) && (mag_ry <= 16'(lim_reg)))
        else $error("stick component beyond stick limit");

endmodule

bind gamepad_input_conditioner gic_checker u_gic_checker (.*);

`default_nettype wire
